@@ sv/rgbdith_pkg.sv @@
`timescale 1ns / 1ps

package rgbdith_pkg;

  // Configuration register widths and reset values
  localparam int CFG_WIDTH_W  = 13;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Channel order inside packed triples
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Diffusion weights, in sixteenths
  localparam logic [2:0] K_RIGHT      = 3'd7;
  localparam logic [2:0] K_BELOW      = 3'd5;
  localparam logic [2:0] K_BELOW_LEFT = 3'd3;
  localparam logic [2:0] K_BELOW_RGT  = 3'd1;

  typedef logic signed [7:0] err_t;
  typedef err_t [0:2] err3_t;          // 24 bits, one line entry
  typedef logic [0:2][7:0] pix3_t;

  // Item in the compute stage, position flags resolved at accept
  typedef struct packed {
    logic  last_col;
    logic  last_row;
    logic  first_row;
    pix3_t pix;
  } stage_t;

  // Red/green palette levels 0,36,73,...,255
  function automatic logic [7:0] level_rg(input logic [2:0] k);
    logic [7:0] lv;
    case (k)
      3'd0: lv = 8'd0;
      3'd1: lv = 8'd36;
      3'd2: lv = 8'd73;
      3'd3: lv = 8'd109;
      3'd4: lv = 8'd146;
      3'd5: lv = 8'd182;
      3'd6: lv = 8'd219;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

  // Blue palette levels 0,85,170,255
  function automatic logic [7:0] level_b(input logic [1:0] k);
    logic [7:0] lv;
    case (k)
      2'd0: lv = 8'd0;
      2'd1: lv = 8'd85;
      2'd2: lv = 8'd170;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

  // e*k/16, truncated toward zero
  function automatic err_t share16(input err_t e, input logic [2:0] k);
    logic signed [11:0] p;
    logic signed [11:0] q;
    p = $signed({{4{e[7]}}, e}) * $signed({9'b0, k});
    q = (p < 0) ? p + 12'sd15 : p;
    q = q >>> 4;
    return q[7:0];
  endfunction

endpackage

@@ sv/rgbdith_ram.sv @@
`timescale 1ns / 1ps

module rgbdith_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/rgbdith_front.sv @@
`timescale 1ns / 1ps

module rgbdith_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [rgbdith_pkg::CFG_WIDTH_W-1:0]  cfg_width,
  input  logic [rgbdith_pkg::CFG_HEIGHT_W-1:0] cfg_height,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rgbdith_pkg::pix3_t                   in_pix,
  input  logic                                 fire,
  output logic                                 accept,
  output logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
  output logic                                 s1_valid,
  output rgbdith_pkg::stage_t                  s1,
  output logic [$clog2(MAX_WIDTH)-1:0]         s1_idx
);

  import rgbdith_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > CFG_WIDTH_W) ? CW + 1 : CFG_WIDTH_W;

  logic [CW-1:0]           col_r, col_nxt;
  logic [CFG_HEIGHT_W-1:0] row_r, row_nxt;
  logic                    s1_valid_r, s1_valid_nxt;
  stage_t                  s1_r;
  logic [CW-1:0]           s1_idx_r;

  logic [EW-1:0]           w_ext, w_lim;
  logic [CW-1:0]           last_pos;
  logic [CFG_HEIGHT_W-1:0] h_last;
  logic                    last_col, last_row;

  // Effective frame size: zero counts as one, width saturates at the line depth
  always_comb begin
    w_ext = EW'(cfg_width);
    if (w_ext == '0) begin
      w_lim = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_lim = EW'(MAX_WIDTH);
    end else begin
      w_lim = w_ext;
    end
    last_pos = CW'(w_lim - EW'(1));
    h_last   = (cfg_height == '0) ? '0 : cfg_height - CFG_HEIGHT_W'(1);
  end

  assign last_col = col_r >= last_pos;
  assign last_row = row_r >= h_last;

  // Stage holds one item; it frees up when the compute stage fires
  assign in_ready = !s1_valid_r || fire;
  assign accept   = in_valid && in_ready;
  assign rd_addr  = col_r;

  // Raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CFG_HEIGHT_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload of the compute stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.last_col  <= last_col;
      s1_r.last_row  <= last_row;
      s1_r.first_row <= (row_r == '0);
      s1_r.pix       <= in_pix;
      s1_idx_r       <= col_r;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign s1_idx   = s1_idx_r;

`ifndef ASSERT_OFF
  a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_valid_r |-> fire)
    else $error("item accepted over an occupied stage");

  a_wrap_at_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_col |=> col_r == '0)
    else $error("column did not wrap");
`endif

endmodule

@@ sv/rgbdith_core.sv @@
`timescale 1ns / 1ps

module rgbdith_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  rgbdith_pkg::err3_t           rd_data,
  input  logic                         fire,
  input  rgbdith_pkg::stage_t          s1,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_idx,
  output logic [7:0]                   color,
  output logic                         wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output rgbdith_pkg::err3_t           wr_data
);

  import rgbdith_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  err3_t carry_r, carry_nxt;
  err3_t pend0_r, pend0_nxt;   // below sum for the previous column
  err3_t pend1_r, pend1_nxt;   // below-right share of the current column

  // Last-column entry is held until the write port is free
  logic          defer_valid_r, defer_valid_nxt;
  logic [CW-1:0] defer_addr_r;
  err3_t         defer_data_r;

  // Writes that landed after this stage's line read was issued
  logic          ovr_valid_r, ovr_valid_nxt;
  err3_t         ovr_data_r, ovr_data_nxt;

  err3_t              below;
  logic signed [9:0]  x [3];
  logic [7:0]         v [3];
  logic [7:0]         lvl [3];
  logic signed [8:0]  diff [3];
  err3_t              e, sh7, sh5, sh3, sh1;
  logic               a_wr, b_new;
  err3_t              a_data, b_data;

  // Line entry for this item, newest write first
  always_comb begin
    if (s1.first_row) begin
      below = '0;
    end else if (defer_valid_r && defer_addr_r == s1_idx) begin
      below = defer_data_r;
    end else if (ovr_valid_r) begin
      below = ovr_data_r;
    end else begin
      below = rd_data;
    end
  end

  // Per channel: add diffused error, clamp, quantize, split the error
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x[c] = $signed({2'b00, s1.pix[c]}) + $signed({{2{carry_r[c][7]}}, carry_r[c]})
           + $signed({{2{below[c][7]}}, below[c]});
      if (x[c] < 0) begin
        v[c] = 8'd0;
      end else if (x[c] > 10'sd255) begin
        v[c] = 8'd255;
      end else begin
        v[c] = x[c][7:0];
      end
      lvl[c]  = (c == CH_BLUE) ? level_b(v[c][7:6]) : level_rg(v[c][7:5]);
      diff[c] = $signed({1'b0, v[c]}) - $signed({1'b0, lvl[c]});
      e[c]    = diff[c][7:0];
      sh7[c]  = share16(e[c], K_RIGHT);
      sh5[c]  = share16(e[c], K_BELOW);
      sh3[c]  = share16(e[c], K_BELOW_LEFT);
      sh1[c]  = share16(e[c], K_BELOW_RGT);
      a_data[c] = pend0_r[c] + sh3[c];
      b_data[c] = pend1_r[c] + sh5[c];
    end
  end

  assign color = {v[CH_RED][7:5], v[CH_GREEN][7:5], v[CH_BLUE][7:6]};

  // Below-left entry is final now; the last column's own entry is deferred
  assign a_wr  = fire && !s1.last_row && (s1_idx != '0);
  assign b_new = fire && !s1.last_row && s1.last_col;

  // Single write port: a deferred entry never meets a below-left write
  always_comb begin
    wr_en   = a_wr || defer_valid_r;
    wr_addr = a_wr ? s1_idx - CW'(1) : defer_addr_r;
    wr_data = a_wr ? a_data : defer_data_r;
  end

  // Row carries
  always_comb begin
    carry_nxt = carry_r;
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    if (fire) begin
      carry_nxt = s1.last_col ? '0 : sh7;
      if (s1.last_row || s1.last_col) begin
        pend0_nxt = '0;
        pend1_nxt = '0;
      end else begin
        pend0_nxt = b_data;
        pend1_nxt = sh1;
      end
    end
  end

  always_comb begin
    if (b_new) begin
      defer_valid_nxt = 1'b1;
    end else if (a_wr) begin
      defer_valid_nxt = defer_valid_r;
    end else begin
      defer_valid_nxt = 1'b0;
    end
  end

  // Track writes to the entry read for the item in this stage
  always_comb begin
    ovr_valid_nxt = ovr_valid_r;
    ovr_data_nxt  = ovr_data_r;
    if (accept) begin
      ovr_valid_nxt = wr_en && (wr_addr == rd_addr);
      ovr_data_nxt  = wr_data;
    end else if (wr_en && (wr_addr == s1_idx)) begin
      ovr_valid_nxt = 1'b1;
      ovr_data_nxt  = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r       <= '0;
      pend0_r       <= '0;
      pend1_r       <= '0;
      defer_valid_r <= 1'b0;
      ovr_valid_r   <= 1'b0;
    end else begin
      carry_r       <= carry_nxt;
      pend0_r       <= pend0_nxt;
      pend1_r       <= pend1_nxt;
      defer_valid_r <= defer_valid_nxt;
      ovr_valid_r   <= ovr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_new) begin
      defer_addr_r <= s1_idx;
      defer_data_r <= b_data;
    end
    ovr_data_r <= ovr_data_nxt;
  end

`ifndef ASSERT_OFF
  a_port_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(a_wr && defer_valid_r))
    else $error("below-left write collides with deferred entry");

  a_defer_drains: assert property (@(posedge clk) disable iff (!rst_n)
    defer_valid_r && !b_new |=> !defer_valid_r)
    else $error("deferred entry not written back");

  a_defer_capture: assert property (@(posedge clk) disable iff (!rst_n)
    b_new |=> defer_valid_r && defer_addr_r == $past(s1_idx))
    else $error("last column entry not held for write");
`endif

endmodule

@@ sv/rgb332_error_diffusion_dither.sv @@
`timescale 1ns / 1ps

// Channel   Ports                                 Handshake
// input     in_red, in_green, in_blue             in_valid / in_ready
// result    out_color_index                       out_valid / out_ready
// config    cfg_index, cfg_data                   cfg_write_en, no wait
//
// One item per clock sustained while out_ready is high; an accepted item is registered in the
// compute stage, then in the output register. The error line sits in one RAM (one write, one read
// port); the read is issued at accept and the entry is rebuilt in the compute stage, with late
// writes forwarded. Reset is synchronous, active low; the line RAM is not cleared and the first
// row of a frame never reads it. in_ready drops only while the compute stage
// holds an item and the output register is full and not being taken.

module rgb332_error_diffusion_dither #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_color_index,
  input  logic                                cfg_write_en,
  input  rgbdith_pkg::cfg_reg_t               cfg_index,
  input  logic [rgbdith_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rgbdith_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;

  logic          accept, fire, s1_valid;
  logic [CW-1:0] rd_addr, s1_idx, wr_addr;
  stage_t        s1;
  pix3_t         in_pix;
  err3_t         rd_data, wr_data;
  logic          wr_en;
  logic [7:0]    color;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_color_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_pix[CH_RED]   = in_red;
    in_pix[CH_GREEN] = in_green;
    in_pix[CH_BLUE]  = in_blue;
  end

  // Compute stage advances when the output register has room
  assign fire = s1_valid && (!out_valid_r || out_ready);

  rgbdith_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pix     (in_pix),
    .fire       (fire),
    .accept     (accept),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_idx     (s1_idx)
  );

  rgbdith_ram #(.WIDTH($bits(err3_t)), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rgbdith_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .fire    (fire),
    .s1      (s1),
    .s1_idx  (s1_idx),
    .color   (color),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_color_r <= color;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_color_r;

`ifndef ASSERT_OFF
  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("fired item missing from output register");

  a_no_fire_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !fire)
    else $error("compute stage overwrote a held result");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid)
    else $error("accepted item lost before compute stage");
`endif

endmodule
